// ===== src/jpeg_marker_scanner_assert.svh =====
// Assertion macros for the JPEG marker scanner.
// Included by the RTL files that carry assertions; no other dependency.
`ifndef JPEG_MARKER_SCANNER_ASSERT_SVH
`define JPEG_MARKER_SCANNER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define JMS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("jpeg_marker_scanner: assertion failed");
// Next-cycle implication.
`define JMS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("jpeg_marker_scanner: assertion failed");
// Invariant that holds at every edge out of reset.
`define JMS_ASSERT_ALW(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("jpeg_marker_scanner: assertion failed");
`else
`define JMS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define JMS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`define JMS_ASSERT_ALW(lbl, clk, rstn, expr)
`endif
`endif

// ===== src/jms_pkg.sv =====
// Shared types and constants of the JPEG marker scanner.
// No dependencies; imported by every module of the block.
`default_nettype none
package jms_pkg;

    // Input word: one file byte and its last-byte flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_t;

    // Result word: one record per marker header or final result
    typedef struct packed {
        logic [15:0] marker_code;
        logic [15:0] segment_length;
        logic        is_final;
        logic [1:0]  scan_status;
        logic [15:0] frame_height;
        logic [15:0] frame_width;
        logic [2:0]  exif_status;
        logic        exif_little_endian;
    } out_t;

    // Record from the step logic to the output register
    typedef struct packed {
        logic vld;
        out_t rec;
    } res_t;

    // Parser phases
    typedef enum logic [7:0] {
        PH_SOI0   = 8'b0000_0001,
        PH_SOI1   = 8'b0000_0010,
        PH_M0     = 8'b0000_0100,
        PH_M1     = 8'b0000_1000,
        PH_L0     = 8'b0001_0000,
        PH_L1     = 8'b0010_0000,
        PH_PAY    = 8'b0100_0000,
        PH_IGNORE = 8'b1000_0000
    } phase_t;

    // Scan status codes
    localparam logic [1:0] ST_SOS     = 2'd0;
    localparam logic [1:0] ST_NO_SOI  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_TRUNC   = 2'd3;

    // Exif check codes; pending is internal only
    localparam logic [2:0] EX_NONE       = 3'd0;
    localparam logic [2:0] EX_VALID      = 3'd1;
    localparam logic [2:0] EX_BAD_IDENT  = 3'd2;
    localparam logic [2:0] EX_BAD_2A     = 3'd3;
    localparam logic [2:0] EX_BAD_OFFSET = 3'd4;
    localparam logic [2:0] EX_PENDING    = 3'd5;

    // Marker words and Exif header constants
    localparam logic [15:0] MK_SOI      = 16'hFFD8;
    localparam logic [15:0] MK_SOS      = 16'hFFDA;
    localparam logic [15:0] MK_MIN      = 16'hFF00;
    localparam logic [15:0] MK_SOF0     = 16'hFFC0;
    localparam logic [15:0] MK_SOF2     = 16'hFFC2;
    localparam logic [15:0] MK_APP1     = 16'hFFE1;
    localparam logic [31:0] EXIF_IDENT  = 32'h4578_6966;
    localparam logic [15:0] TIFF_LE     = 16'h4949;
    localparam logic [15:0] TIFF_MAGIC  = 16'h002A;
    localparam logic [31:0] TIFF_OFFSET = 32'd8;

endpackage
`default_nettype wire

// ===== src/jpeg_marker_scanner.sv =====
// Top level of the JPEG marker scanner: input register, parser, result register.
// Depends on jms_pkg, jms_in_stage, jms_core and jms_out_stage.
//
//   Port group   Dir  Handshake         Word
//   s_*          in   s_valid/s_ready   jms_pkg::in_t  (data_byte, end_of_file)
//   m_*          out  m_valid/m_ready   jms_pkg::out_t (one marker record)
//
// One byte per cycle sustained while the result slot stays free; a record reaches
// m_* through the input register, then the result register after the parser step.
// The parser step is a single pass of compare and small-add logic per byte.
// Reset (aresetn low, synchronous) clears both stages and all parser state.
// While m_ready is low with a record waiting, the parser stalls and the input
// register takes one more byte only if it is empty.
`default_nettype none
module jpeg_marker_scanner (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  jms_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output jms_pkg::out_t m_data
);
    import jms_pkg::*;

    logic advance;
    logic item_vld;
    in_t  item;
    res_t res;

    // Step the parser when a byte waits and the result slot is free
    assign advance = item_vld && (!m_valid || m_ready);

    jms_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .advance  (advance),
        .item_vld (item_vld),
        .item     (item)
    );

    jms_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item),
        .res     (res)
    );

    jms_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && res.vld),
        .rec     (res.rec),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ===== src/jms_in_stage.sv =====
// Input register of the JPEG marker scanner: holds one byte word.
// Depends on jms_pkg.
`default_nettype none
module jms_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  jms_pkg::in_t  s_data,
    input  logic          advance,
    output logic          item_vld,
    output jms_pkg::in_t  item
);
    import jms_pkg::*;

    logic vld_reg;
    in_t  data_reg;

    // Take a word whenever the slot is empty or drains this cycle
    assign s_ready  = !vld_reg || advance;
    assign item_vld = vld_reg;
    assign item     = data_reg;

    // Track occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            vld_reg <= 1'b1;
        end else if (advance) begin
            vld_reg <= 1'b0;
        end
    end

    // Capture the payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule
`default_nettype wire

// ===== src/jms_core.sv =====
// Parser state and per-byte step logic of the JPEG marker scanner.
// Depends on jms_pkg and jpeg_marker_scanner_assert.svh.
`default_nettype none
`include "jpeg_marker_scanner_assert.svh"
module jms_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  jms_pkg::in_t  item,
    output jms_pkg::res_t res
);
    import jms_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [15:0] cnt_reg,    cnt_next;
    logic [15:0] marker_reg, marker_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] width_reg,  width_next;
    logic        app1_reg,   app1_next;
    logic [31:0] shift_reg,  shift_next;
    logic [2:0]  exif_reg,   exif_next;
    logic        le_reg,     le_next;

    logic        eof;
    logic [7:0]  b;
    logic [15:0] paylen_cur;
    logic [15:0] paylen_new;
    logic [15:0] cnt_inc;
    logic        end_pay;
    logic        returned;
    logic        fin;
    logic [1:0]  status;
    logic        emit;
    logic [15:0] w16;
    logic [31:0] w32;

    assign eof        = item.end_of_file;
    assign b          = item.data_byte;
    assign paylen_cur = (length_reg >= 16'd2) ? (length_reg - 16'd2) : 16'd0;
    assign cnt_inc    = cnt_reg + 16'd1;

    // One parser step for the byte in the input register
    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        marker_next = marker_reg;
        length_next = length_reg;
        height_next = height_reg;
        width_next  = width_reg;
        app1_next   = app1_reg;
        shift_next  = shift_reg;
        exif_next   = exif_reg;
        le_next     = le_reg;
        paylen_new  = 16'd0;
        end_pay     = 1'b0;
        returned    = 1'b0;
        fin         = 1'b0;
        status      = ST_SOS;
        emit        = 1'b0;
        w16         = 16'd0;
        w32         = 32'd0;

        unique case (phase_reg)
            PH_SOI0: begin
                cnt_next   = {8'd0, b};
                phase_next = PH_SOI1;
            end
            PH_SOI1: begin
                if ({cnt_reg[7:0], b} != MK_SOI) begin
                    returned = 1'b1;
                    emit     = 1'b1;
                    fin      = 1'b1;
                    status   = ST_NO_SOI;
                end else begin
                    cnt_next   = 16'd0;
                    app1_next  = 1'b1;
                    phase_next = PH_M0;
                end
            end
            PH_M0: begin
                cnt_next   = {8'd0, b};
                phase_next = PH_M1;
            end
            PH_M1: begin
                marker_next = {cnt_reg[7:0], b};
                phase_next  = PH_L0;
            end
            PH_L0: begin
                cnt_next   = {8'd0, b};
                phase_next = PH_L1;
            end
            PH_L1: begin
                returned    = 1'b1;
                emit        = 1'b1;
                length_next = {cnt_reg[7:0], b};
                cnt_next    = 16'd0;
                paylen_new  = (length_next >= 16'd2) ? (length_next - 16'd2) : 16'd0;
                if (marker_reg < MK_MIN) begin
                    fin    = 1'b1;
                    status = ST_INVALID;
                end else if (marker_reg == MK_SOS) begin
                    fin    = 1'b1;
                    status = ST_SOS;
                end else begin
                    if (app1_reg) begin
                        if (marker_reg == MK_APP1) begin
                            exif_next  = EX_PENDING;
                            shift_next = 32'd0;
                        end else begin
                            app1_next = 1'b0;
                        end
                    end
                    if (paylen_new == 16'd0) begin
                        end_pay = 1'b1;
                    end else begin
                        phase_next = PH_PAY;
                    end
                    if (eof) begin
                        fin    = 1'b1;
                        status = ST_TRUNC;
                    end
                end
            end
            PH_PAY: begin
                // Capture frame size from SOF0 or SOF2
                if (marker_reg == MK_SOF0 || marker_reg == MK_SOF2) begin
                    if (cnt_reg == 16'd1) begin
                        height_next = {b, 8'd0};
                    end else if (cnt_reg == 16'd2) begin
                        height_next = {height_reg[15:8], b};
                    end else if (cnt_reg == 16'd3) begin
                        width_next = {b, 8'd0};
                    end else if (cnt_reg == 16'd4) begin
                        width_next = {width_reg[15:8], b};
                    end
                end
                // Check the Exif header bytes
                if (exif_reg == EX_PENDING) begin
                    shift_next = {shift_reg[23:0], b};
                    if (cnt_reg == 16'd3) begin
                        if (shift_next != EXIF_IDENT) begin
                            exif_next = EX_BAD_IDENT;
                        end
                    end else if (cnt_reg == 16'd7) begin
                        le_next = (shift_next[15:0] == TIFF_LE);
                    end else if (cnt_reg == 16'd9) begin
                        w16 = le_reg ? {shift_next[7:0], shift_next[15:8]}
                                     : shift_next[15:0];
                        if (w16 != TIFF_MAGIC) begin
                            exif_next = EX_BAD_2A;
                        end
                    end else if (cnt_reg == 16'd13) begin
                        w32 = le_reg ? {shift_next[7:0], shift_next[15:8],
                                        shift_next[23:16], shift_next[31:24]}
                                     : shift_next;
                        exif_next = (w32 == TIFF_OFFSET) ? EX_VALID : EX_BAD_OFFSET;
                    end
                end
                cnt_next = cnt_inc;
                if (cnt_inc >= paylen_cur) begin
                    end_pay = 1'b1;
                end
            end
            PH_IGNORE: begin
                returned = 1'b1;
                if (eof) begin
                    phase_next = PH_SOI0;
                end
            end
            default: begin
                phase_next = PH_SOI0;
            end
        endcase

        // Close the payload; an unfinished Exif check fails at its stage
        if (end_pay) begin
            if (exif_next == EX_PENDING) begin
                if (cnt_next < 16'd4) begin
                    exif_next = EX_BAD_IDENT;
                end else if (cnt_next < 16'd10) begin
                    exif_next = EX_BAD_2A;
                end else begin
                    exif_next = EX_BAD_OFFSET;
                end
            end
            app1_next  = 1'b0;
            phase_next = PH_M0;
        end

        // Flag truncation on a marked byte that gave no final result
        if (!returned && eof) begin
            emit   = 1'b1;
            fin    = 1'b1;
            status = ST_TRUNC;
        end

        // Build the record from the updated state
        res.vld                    = emit;
        res.rec.marker_code        = marker_next;
        res.rec.segment_length     = length_next;
        res.rec.is_final           = fin;
        res.rec.scan_status        = fin ? status : ST_SOS;
        res.rec.frame_height       = height_next;
        res.rec.frame_width        = width_next;
        res.rec.exif_status        = (exif_next <= EX_BAD_OFFSET) ? exif_next : EX_NONE;
        res.rec.exif_little_endian = le_next;

        // Drop to the next file or skip the rest of this one
        if (fin || (phase_reg == PH_IGNORE && eof)) begin
            if (eof) begin
                phase_next  = PH_SOI0;
                cnt_next    = 16'd0;
                marker_next = 16'd0;
                length_next = 16'd0;
                height_next = 16'd0;
                width_next  = 16'd0;
                app1_next   = 1'b0;
                shift_next  = 32'd0;
                exif_next   = EX_NONE;
                le_next     = 1'b0;
            end else begin
                phase_next = PH_IGNORE;
            end
        end
    end

    // Advance the parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SOI0;
            cnt_reg    <= 16'd0;
            marker_reg <= 16'd0;
            length_reg <= 16'd0;
            height_reg <= 16'd0;
            width_reg  <= 16'd0;
            app1_reg   <= 1'b0;
            shift_reg  <= 32'd0;
            exif_reg   <= EX_NONE;
            le_reg     <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            marker_reg <= marker_next;
            length_reg <= length_next;
            height_reg <= height_next;
            width_reg  <= width_next;
            app1_reg   <= app1_next;
            shift_reg  <= shift_next;
            exif_reg   <= exif_next;
            le_reg     <= le_next;
        end
    end

    `JMS_ASSERT_ALW(a_phase_onehot, aclk, aresetn, $onehot(phase_reg))
    `JMS_ASSERT_ALW(a_exif_range, aclk, aresetn, exif_reg <= EX_PENDING)
    `JMS_ASSERT_NXT(a_final_skips, aclk, aresetn, step && res.vld && res.rec.is_final && !eof,
                    phase_reg == PH_IGNORE)
    `JMS_ASSERT_NXT(a_eof_restarts, aclk, aresetn, step && eof,
                    phase_reg == PH_SOI0 && marker_reg == 16'd0 && exif_reg == EX_NONE)

endmodule
`default_nettype wire

// ===== src/jms_out_stage.sv =====
// Result register of the JPEG marker scanner: holds one result word.
// Depends on jms_pkg and jpeg_marker_scanner_assert.svh.
`default_nettype none
`include "jpeg_marker_scanner_assert.svh"
module jms_out_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  jms_pkg::out_t rec,
    input  logic          m_ready,
    output logic          m_valid,
    output jms_pkg::out_t m_data
);
    import jms_pkg::*;

    logic vld_reg;
    out_t data_reg;

    assign m_valid = vld_reg;
    assign m_data  = data_reg;

    // Fill on a new record, drain when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (load) begin
            vld_reg <= 1'b1;
        end else if (m_ready) begin
            vld_reg <= 1'b0;
        end
    end

    // Hold the record until taken
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= rec;
        end
    end

    `JMS_ASSERT_IMP(a_no_overwrite, aclk, aresetn, load, !vld_reg || m_ready)

endmodule
`default_nettype wire
